// File: rtl/core/km_pkg.sv
package km_pkg;

  // register indexes on the configuration port
  typedef enum logic [0:0] {
    CFG_PERCENT = 1'b0,
    CFG_EPS     = 1'b1
  } cfg_index_t;

  localparam int CFG_DATA_W = 15;
  localparam int KM_W       = 31;
  localparam logic [KM_W-1:0] KM_MAX = 31'h7FFF_FFFF;

  // x / 100 == (x * PCT_RECIP) >> PCT_SHIFT, exact for 0 <= x < 2^31
  localparam logic [31:0] PCT_RECIP = 32'd2748779070;
  localparam int          PCT_SHIFT = 38;
  localparam int          PCT_Q_W   = 25;

  // stage payload between the front end and the divider
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

// File: rtl/core/km_div.sv
// Restoring divider, one quotient bit per pipeline stage.
module km_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  km_pkg::stage_ctl_t        in_ctl,
  input  logic [2*FRAC_BITS-1:0]    dividend,
  input  logic [FRAC_BITS:0]        divisor,
  output km_pkg::stage_ctl_t        out_ctl,
  output logic [2*FRAC_BITS-1:0]    quotient
);

  localparam int QW = 2 * FRAC_BITS;
  localparam int DW = FRAC_BITS + 1;

  km_pkg::stage_ctl_t ctl [QW];
  logic [DW-1:0]      rem [QW];
  logic [QW-1:0]      dd  [QW];
  logic [QW-1:0]      quo [QW];
  logic [DW-1:0]      dv  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    km_pkg::stage_ctl_t c_ctl;
    logic [DW-1:0]      c_rem;
    logic [QW-1:0]      c_dd;
    logic [QW-1:0]      c_quo;
    logic [DW-1:0]      c_dv;
    logic [DW:0]        trial;
    logic               ge;

    if (k == 0) begin : g_first
      always_comb begin
        c_ctl = in_ctl;
        c_rem = '0;
        c_dd  = dividend;
        c_quo = '0;
        c_dv  = divisor;
      end
    end else begin : g_next
      always_comb begin
        c_ctl = ctl[k-1];
        c_rem = rem[k-1];
        c_dd  = dd[k-1];
        c_quo = quo[k-1];
        c_dv  = dv[k-1];
      end
    end

    always_comb begin
      trial = {c_rem, c_dd[QW-1]};
      ge    = trial >= {1'b0, c_dv};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k].valid <= 1'b0;
      end else if (en) begin
        ctl[k].valid <= c_ctl.valid;
      end
      if (en) begin
        ctl[k].last <= c_ctl.last;
        rem[k]      <= ge ? DW'(trial - {1'b0, c_dv}) : DW'(trial);
        dd[k]       <= {c_dd[QW-2:0], 1'b0};
        quo[k]      <= {c_quo[QW-2:0], ge};
        dv[k]       <= c_dv;
      end
    end
  end

  assign out_ctl  = ctl[QW-1];
  assign quotient = quo[QW-1];

  // remainder stays below the divisor once a word is in flight
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ctl[0].valid && dv[0] != '0 |-> rem[0] < dv[0])
    else $error("divider remainder out of range");

  // held pipeline keeps its last stage
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(quo[QW-1]) && $stable(ctl[QW-1]))
    else $error("divider moved while stalled");

  // a word in flight advances exactly one stage per enabled cycle
  a_shift: assert property (@(posedge clk) disable iff (rst)
    en && ctl[0].valid |=> ctl[1 % QW].valid || QW == 1)
    else $error("divider lost a word");

endmodule

// File: rtl/core/kubelka_munk_transform.sv
// Channel | Signals                               | Direction
// input   | in_valid, in_ready, reflectance, in_last | into block
// output  | out_valid, out_ready, km_value, out_last | out of block
// config  | cfg_write, cfg_index, cfg_data        | into block, no wait
//
// One word per cycle sustained while out_ready stays high; pipeline depth is set by the
// restoring divider that resolves one quotient bit per stage.
// Synchronous active-high reset clears valid bits and the registers
// (percent mode off, epsilon 1). A stall at the output freezes the whole
// pipeline; an input skid register keeps in_ready a registered signal.
module kubelka_munk_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [31:0]              reflectance,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [km_pkg::KM_W-1:0]         km_value,
  output logic                            out_last,
  input  logic                            cfg_write,
  input  km_pkg::cfg_index_t              cfg_index,
  input  logic [km_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int FB  = FRAC_BITS;
  localparam int QW  = 2 * FB;
  localparam int QX  = (QW > km_pkg::KM_W) ? QW : km_pkg::KM_W;
  localparam int SHL = (FB >= 16) ? FB - 16 : 0;
  localparam int SHR = (FB < 16) ? 16 - FB : 0;
  localparam logic signed [32:0] ONE = 33'sd1 <<< FB;

  // configuration
  logic                          percent_mode;
  logic [km_pkg::CFG_DATA_W-1:0] clamp_epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_mode  <= 1'b0;
      clamp_epsilon <= km_pkg::CFG_DATA_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        km_pkg::CFG_PERCENT: percent_mode  <= cfg_data[0];
        km_pkg::CFG_EPS:     clamp_epsilon <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp bounds
  logic [FB+15:0]         eps_w;
  logic signed [32:0]     lo;
  logic signed [32:0]     hi;

  always_comb begin
    eps_w = ((FB+16)'(clamp_epsilon) << SHL) >> SHR;
    lo    = (eps_w == '0) ? 33'sd1 : $signed(33'(eps_w));
    hi    = ONE - lo;
  end

  // global advance
  logic en;
  logic last_valid;
  assign en = !last_valid || out_ready;

  // input skid
  logic               skid_valid;
  logic signed [31:0] skid_x;
  logic               skid_last;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
    if (!en && in_valid && in_ready) begin
      skid_x    <= reflectance;
      skid_last <= in_last;
    end
  end

  logic               src_valid;
  logic signed [31:0] src_x;
  logic               src_last;

  always_comb begin
    src_valid = skid_valid || in_valid;
    src_x     = skid_valid ? skid_x : reflectance;
    src_last  = skid_valid ? skid_last : in_last;
  end

  // stage 0: entry
  km_pkg::stage_ctl_t s0_ctl;
  logic signed [31:0] s0_x;

  // stage 1: percent reciprocal product
  km_pkg::stage_ctl_t           s1_ctl;
  logic signed [31:0]           s1_x;
  logic [km_pkg::PCT_Q_W-1:0]   s1_pq;
  logic [62:0]                  prod;

  assign prod = {32'd0, s0_x[30:0]} * {31'd0, km_pkg::PCT_RECIP};

  // stage 2: clamp
  km_pkg::stage_ctl_t s2_ctl;
  logic [FB-1:0]      s2_r;
  logic [FB-1:0]      s2_diff;
  logic signed [32:0] xs;
  logic signed [32:0] rc;
  logic signed [32:0] dfull;

  always_comb begin
    if (percent_mode) begin
      xs = (s1_x <= 0) ? lo : $signed({8'd0, s1_pq});
    end else begin
      xs = 33'(s1_x);
    end
    if (xs < lo) begin
      rc = lo;
    end else if (xs > hi) begin
      rc = hi;
    end else begin
      rc = xs;
    end
    dfull = ONE - rc;
  end

  // stage 3: square and doubled divisor
  km_pkg::stage_ctl_t s3_ctl;
  logic [QW-1:0]      s3_sq;
  logic [FB:0]        s3_dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_ctl.valid <= 1'b0;
      s1_ctl.valid <= 1'b0;
      s2_ctl.valid <= 1'b0;
      s3_ctl.valid <= 1'b0;
    end else if (en) begin
      s0_ctl.valid <= src_valid;
      s1_ctl.valid <= s0_ctl.valid;
      s2_ctl.valid <= s1_ctl.valid;
      s3_ctl.valid <= s2_ctl.valid;
    end
    if (en) begin
      s0_ctl.last <= src_last;
      s0_x        <= src_x;
      s1_ctl.last <= s0_ctl.last;
      s1_x        <= s0_x;
      s1_pq       <= prod[km_pkg::PCT_SHIFT +: km_pkg::PCT_Q_W];
      s2_ctl.last <= s1_ctl.last;
      s2_r        <= FB'(rc);
      s2_diff     <= FB'(dfull);
      s3_ctl.last <= s2_ctl.last;
      s3_sq       <= QW'({{FB{1'b0}}, s2_diff} * {{FB{1'b0}}, s2_diff});
      s3_dv       <= {s2_r, 1'b0};
    end
  end

  // divider
  km_pkg::stage_ctl_t dv_ctl;
  logic [QW-1:0]      dv_q;

  km_div #(
    .FRAC_BITS (FB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctl   (s3_ctl),
    .dividend (s3_sq),
    .divisor  (s3_dv),
    .out_ctl  (dv_ctl),
    .quotient (dv_q)
  );

  // output register with saturation
  logic [QX-1:0] qx;
  assign qx = QX'(dv_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else if (en) begin
      last_valid <= dv_ctl.valid;
    end
    if (en) begin
      km_value <= (qx > QX'(km_pkg::KM_MAX)) ? km_pkg::KM_MAX : qx[km_pkg::KM_W-1:0];
      out_last <= dv_ctl.last;
    end
  end

  assign out_valid = last_valid;

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !en |=> skid_valid)
    else $error("stalled word not caught in skid");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !en |=> skid_valid && $stable(skid_x))
    else $error("skid word lost during stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(km_value) && $stable(out_last))
    else $error("result changed while stalled");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    s2_ctl.valid |-> s2_r != '0 && s2_diff != '0)
    else $error("clamp produced zero divisor or difference");

endmodule

// File: tb/tb.sv
module tb;

  localparam int FB       = 16;
  localparam int LATENCY  = 2 * FB + 5;
  localparam int WD_LIMIT = 20000;

  // expected km words, checked in order
  class km_scoreboard;
    logic [km_pkg::KM_W-1:0] km_q[$];
    logic                    last_q[$];
    int                      errors;
    logic                    pct;
    logic [14:0]             eps;

    function new();
      errors = 0;
      pct    = 1'b0;
      eps    = 15'd1;
    endfunction

    function void note_input(logic signed [31:0] refl, logic lst);
      longint      one;
      longint      lo;
      longint      x;
      longint      hi;
      longint unsigned diff;
      longint unsigned q;
      one = longint'(1) << FB;
      if (FB >= 16) lo = longint'(eps) << (FB - 16);
      else lo = longint'(eps) >>> (16 - FB);
      if (lo < 1) lo = 1;
      hi = one - lo;
      x = refl;
      if (pct) begin
        if (x <= 0) x = lo;
        else x = x / 100;
      end
      if (x < lo) x = lo;
      else if (x > hi) x = hi;
      diff = longint'(one - x);
      q = (diff * diff) / (2 * longint'(x));
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      km_q.push_back(q[km_pkg::KM_W-1:0]);
      last_q.push_back(lst);
    endfunction

    function void check_result(logic [km_pkg::KM_W-1:0] km, logic lst);
      logic [km_pkg::KM_W-1:0] ekm;
      logic                    elst;
      if (km_q.size() == 0) begin
        $error("unexpected word: km_value=%0d out_last=%0b", km, lst);
        errors++;
        return;
      end
      ekm  = km_q.pop_front();
      elst = last_q.pop_front();
      if (km !== ekm) begin
        $error("km_value: expected %0d actual %0d", ekm, km);
        errors++;
      end
      if (lst !== elst) begin
        $error("out_last: expected %0b actual %0b", elst, lst);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [31:0]            reflectance = '0;
  logic                          in_last = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [km_pkg::KM_W-1:0]       km_value;
  logic                          out_last;
  logic                          cfg_write = 1'b0;
  km_pkg::cfg_index_t            cfg_index = km_pkg::CFG_PERCENT;
  logic [km_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  km_scoreboard sb = new();
  bit  calm;        // end of run: no idling
  bit  hold_rx;     // long receiver hold-off request
  int  idle_cycles;

  always #1 clk = ~clk;

  kubelka_munk_transform #(.FRAC_BITS(FB)) u_dut (.*);

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        for (n = 0; n < 300; n++) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(km_value, out_last);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays up between back-to-back words; drain() drops it
  task automatic send_word(logic signed [31:0] r, logic lst);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 7);
      repeat (n) @(posedge clk);
    end
    in_valid    <= 1'b1;
    reflectance <= r;
    in_last     <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(r, lst);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.km_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(km_pkg::cfg_index_t idx, logic [km_pkg::CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == km_pkg::CFG_PERCENT) sb.pct = d[0];
    else sb.eps = d;
  endtask

  function automatic logic signed [31:0] rand_refl(bit pct_mode);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0001_0000);
      2: return pct_mode ? $urandom_range(0, 32'd6553600) : $urandom_range(0, 32'h1_0000);
      3: return -$signed(32'($urandom_range(0, 32'h7FFF_FFFF)));
      4: return $urandom_range(0, 1000);
      default: return 32'h0001_0000 - $urandom_range(0, 1000);
    endcase
  endfunction

  task automatic run_phase(bit pct, logic [14:0] eps, int count);
    int i;
    write_reg(km_pkg::CFG_PERCENT, {14'd0, pct});
    write_reg(km_pkg::CFG_EPS, eps);
    for (i = 0; i < count; i++) send_word(rand_refl(pct), 1'($urandom_range(0, 1)));
    drain();
  endtask

  initial begin
    int i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset config, extremes, clamp edges, then percent mode and maximum epsilon
    send_word(32'sh8000_0000, 1'b1);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sd0, 1'b1);
    send_word(32'sd1, 1'b0);
    send_word(32'sd2, 1'b0);
    send_word(32'sh0000_8000, 1'b0);
    send_word(32'sh0000_FFFF, 1'b1);
    send_word(32'sh0001_0000, 1'b0);
    send_word(-32'sd1, 1'b0);
    drain();
    write_reg(km_pkg::CFG_PERCENT, 15'd1);
    send_word(32'sd0, 1'b0);
    send_word(-32'sd5, 1'b1);
    send_word(32'sd99, 1'b0);
    send_word(32'sd100, 1'b0);
    send_word(32'sd6553600, 1'b1);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sd3276800, 1'b0);
    drain();
    write_reg(km_pkg::CFG_EPS, 15'h7FFF);
    send_word(32'sd0, 1'b0);
    send_word(32'sh7FFF_FFFF, 1'b1);
    send_word(32'sh0000_8000, 1'b0);
    drain();

    run_phase(1'b0, 15'd1, 250);
    run_phase(1'b1, 15'd1, 200);
    run_phase(1'b0, 15'h7FFF, 100);
    run_phase(1'b1, 15'($urandom_range(1, 32767)), 200);

    // fill the pipe behind a long receiver stall
    hold_rx = 1'b1;
    for (i = 0; i < 150; i++) send_word(rand_refl(1'b1), 1'($urandom_range(0, 1)));
    drain();

    run_phase(1'b0, 15'($urandom_range(1, 2000)), 150);
    calm = 1'b1;
    run_phase(1'b0, 15'd1, 150);

    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/km_pkg.sv
rtl/core/km_div.sv
rtl/core/kubelka_munk_transform.sv
tb/tb.sv
